// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the address core RTL.
// Checks compile away when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLIES(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("implication check failed");
`define ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("next-cycle check failed");
`else
`define ASSERT_IMPLIES(label, clk, rst, a, b)
`define ASSERT_NEXT(label, clk, rst, a, b)
`endif
`endif

// ===== hdl/c2e_pkg.sv =====
// Shared widths, register indexes, face codes and the CORDIC angle table
// for the cubemap to equirectangular address core. No dependencies.
package c2e_pkg;

  localparam int FRAC_BITS     = 16;
  localparam int GUARD_BITS    = 6;
  localparam int MAX_FACE_SIZE = 4096;
  localparam int MAX_SRC_WIDTH = 8192;
  localparam int SRC_HEIGHT_CAP = 4096;
  localparam int CORDIC_STEPS  = FRAC_BITS + 4;

  localparam int PW   = 12;                  // pixel coordinate
  localparam int NW   = 13;                  // clamped face size
  localparam int WW   = 14;                  // clamped source width
  localparam int HW   = 13;                  // clamped source height
  localparam int CHW  = 3;
  localparam int QW   = FRAC_BITS + 1;       // quotient bits
  localparam int NUMW = PW + 1 + FRAC_BITS;  // (2p+1) << FRAC_BITS
  localparam int UW   = FRAC_BITS + 2;       // signed u, v
  localparam int DW   = UW + GUARD_BITS;     // scaled direction component
  localparam int RW   = DW;                  // root bits
  localparam int RADW = 2 * RW;              // radicand bits
  localparam int CW   = DW + 3;              // CORDIC datapath
  localparam int AW   = 32;                  // angle, fraction of a turn
  localparam int COLW = 13;
  localparam int ROWW = 12;
  localparam int OFFW = 27;
  localparam int CFGW = 14;

  localparam int LATENCY = 1 + QW + 3 + RW + 1 + CORDIC_STEPS + 4;

  localparam logic [1:0] REG_FACE_SIZE    = 2'd0;
  localparam logic [1:0] REG_SRC_WIDTH    = 2'd1;
  localparam logic [1:0] REG_SRC_HEIGHT   = 2'd2;
  localparam logic [1:0] REG_SRC_CHANNELS = 2'd3;

  localparam logic [2:0] FACE_PX = 3'd0;
  localparam logic [2:0] FACE_NX = 3'd1;
  localparam logic [2:0] FACE_PY = 3'd2;
  localparam logic [2:0] FACE_NY = 3'd3;
  localparam logic [2:0] FACE_PZ = 3'd4;
  localparam logic [2:0] FACE_NZ = 3'd5;

  localparam logic [AW-1:0] HALF_TURN = 32'h8000_0000;

  // atan(2^-i) in units of 2^-32 turn
  function automatic logic [AW-1:0] atan_turn(input int idx);
    logic [AW-1:0] a;
    case (idx)
      0:  a = 32'd536870912;
      1:  a = 32'd316933406;
      2:  a = 32'd167458907;
      3:  a = 32'd85004756;
      4:  a = 32'd42667331;
      5:  a = 32'd21354465;
      6:  a = 32'd10679838;
      7:  a = 32'd5340245;
      8:  a = 32'd2670163;
      9:  a = 32'd1335087;
      10: a = 32'd667544;
      11: a = 32'd333772;
      12: a = 32'd166886;
      13: a = 32'd83443;
      14: a = 32'd41722;
      15: a = 32'd20861;
      16: a = 32'd10430;
      17: a = 32'd5215;
      18: a = 32'd2608;
      19: a = 32'd1304;
      20: a = 32'd652;
      21: a = 32'd326;
      22: a = 32'd163;
      23: a = 32'd81;
      24: a = 32'd41;
      25: a = 32'd20;
      26: a = 32'd10;
      27: a = 32'd5;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

// ===== hdl/c2e_div_cell.sv =====
// One restoring-division cell: one quotient bit for the u and v lanes.
// Depends on c2e_pkg.
module c2e_div_cell (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [c2e_pkg::NW-1:0]    divisor,
  input  logic                      in_valid,
  input  logic [2:0]                in_face,
  input  logic [c2e_pkg::NW-1:0]    in_rem_u,
  input  logic [c2e_pkg::QW-1:0]    in_low_u,
  input  logic [c2e_pkg::QW-1:0]    in_quo_u,
  input  logic [c2e_pkg::NW-1:0]    in_rem_v,
  input  logic [c2e_pkg::QW-1:0]    in_low_v,
  input  logic [c2e_pkg::QW-1:0]    in_quo_v,
  output logic                      out_valid,
  output logic [2:0]                out_face,
  output logic [c2e_pkg::NW-1:0]    out_rem_u,
  output logic [c2e_pkg::QW-1:0]    out_low_u,
  output logic [c2e_pkg::QW-1:0]    out_quo_u,
  output logic [c2e_pkg::NW-1:0]    out_rem_v,
  output logic [c2e_pkg::QW-1:0]    out_low_v,
  output logic [c2e_pkg::QW-1:0]    out_quo_v
);

  localparam int NW = c2e_pkg::NW;
  localparam int QW = c2e_pkg::QW;

  logic [NW:0] trial_u, trial_v;
  logic        ge_u, ge_v;
  logic [NW:0] diff_u, diff_v;

  always_comb begin
    trial_u = {in_rem_u, in_low_u[QW-1]};
    trial_v = {in_rem_v, in_low_v[QW-1]};
    ge_u    = trial_u >= {1'b0, divisor};
    ge_v    = trial_v >= {1'b0, divisor};
    diff_u  = trial_u - {1'b0, divisor};
    diff_v  = trial_v - {1'b0, divisor};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    out_face  <= in_face;
    out_rem_u <= ge_u ? diff_u[NW-1:0] : trial_u[NW-1:0];
    out_rem_v <= ge_v ? diff_v[NW-1:0] : trial_v[NW-1:0];
    out_low_u <= {in_low_u[QW-2:0], 1'b0};
    out_low_v <= {in_low_v[QW-2:0], 1'b0};
    out_quo_u <= {in_quo_u[QW-2:0], ge_u};
    out_quo_v <= {in_quo_v[QW-2:0], ge_v};
  end

endmodule

// ===== hdl/c2e_sqrt_cell.sv =====
// One digit-by-digit square root cell: one root bit, side data carried along.
// Depends on c2e_pkg.
module c2e_sqrt_cell #(
  parameter int SIDE_W = 1
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  logic [SIDE_W-1:0]           in_side,
  input  logic [c2e_pkg::RW+1:0]      in_rem,
  input  logic [c2e_pkg::RADW-1:0]    in_rad,
  input  logic [c2e_pkg::RW-1:0]      in_root,
  output logic                        out_valid,
  output logic [SIDE_W-1:0]           out_side,
  output logic [c2e_pkg::RW+1:0]      out_rem,
  output logic [c2e_pkg::RADW-1:0]    out_rad,
  output logic [c2e_pkg::RW-1:0]      out_root
);

  localparam int RW   = c2e_pkg::RW;
  localparam int RADW = c2e_pkg::RADW;

  logic [RW+3:0] part;
  logic [RW+3:0] trial;
  logic          ge;
  logic [RW+3:0] diff;

  always_comb begin
    part  = {in_rem, in_rad[RADW-1 -: 2]};
    trial = {2'b00, in_root, 2'b01};
    ge    = part >= trial;
    diff  = part - trial;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    out_side <= in_side;
    out_rem  <= ge ? diff[RW+1:0] : part[RW+1:0];
    out_rad  <= {in_rad[RADW-3:0], 2'b00};
    out_root <= {in_root[RW-2:0], ge};
  end

endmodule

// ===== hdl/c2e_cordic_cell.sv =====
// One CORDIC vectoring step for the longitude and latitude lanes.
// Depends on c2e_pkg (widths and the atan table).
module c2e_cordic_cell #(
  parameter int STEP = 0
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  input  logic                           in_bad,
  input  logic signed [c2e_pkg::CW-1:0]  in_lon_x,
  input  logic signed [c2e_pkg::CW-1:0]  in_lon_y,
  input  logic [c2e_pkg::AW-1:0]         in_lon_a,
  input  logic signed [c2e_pkg::CW-1:0]  in_lat_x,
  input  logic signed [c2e_pkg::CW-1:0]  in_lat_y,
  input  logic [c2e_pkg::AW-1:0]         in_lat_a,
  output logic                           out_valid,
  output logic                           out_bad,
  output logic signed [c2e_pkg::CW-1:0]  out_lon_x,
  output logic signed [c2e_pkg::CW-1:0]  out_lon_y,
  output logic [c2e_pkg::AW-1:0]         out_lon_a,
  output logic signed [c2e_pkg::CW-1:0]  out_lat_x,
  output logic signed [c2e_pkg::CW-1:0]  out_lat_y,
  output logic [c2e_pkg::AW-1:0]         out_lat_a
);

  localparam int CW = c2e_pkg::CW;
  localparam logic [c2e_pkg::AW-1:0] ATAN = c2e_pkg::atan_turn(STEP);

  logic signed [CW-1:0] lon_xs, lon_ys, lat_xs, lat_ys;

  always_comb begin
    lon_xs = in_lon_x >>> STEP;
    lon_ys = in_lon_y >>> STEP;
    lat_xs = in_lat_x >>> STEP;
    lat_ys = in_lat_y >>> STEP;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

  // rotate toward y = 0
  always_ff @(posedge clk) begin
    out_bad <= in_bad;
    if (!in_lon_y[CW-1]) begin
      out_lon_x <= in_lon_x + lon_ys;
      out_lon_y <= in_lon_y - lon_xs;
      out_lon_a <= in_lon_a + ATAN;
    end else begin
      out_lon_x <= in_lon_x - lon_ys;
      out_lon_y <= in_lon_y + lon_xs;
      out_lon_a <= in_lon_a - ATAN;
    end
    if (!in_lat_y[CW-1]) begin
      out_lat_x <= in_lat_x + lat_ys;
      out_lat_y <= in_lat_y - lat_xs;
      out_lat_a <= in_lat_a + ATAN;
    end else begin
      out_lat_x <= in_lat_x - lat_ys;
      out_lat_y <= in_lat_y + lat_xs;
      out_lat_a <= in_lat_a - ATAN;
    end
  end

endmodule

// ===== hdl/cubemap_to_equirect_address_core.sv =====
// Cubemap pixel to equirectangular source address, fully pipelined.
// Stages from the start edge to the done strobe: 17 divider cells,
// 24 square root cells, 20 CORDIC cells, plus input, mapping and output stages.
// Throughput: one pixel per cycle while busy is low; done cannot be held off.
// Reset (rst, synchronous) clears the pipeline and loads the default registers.
// Uses c2e_pkg, c2e_div_cell, c2e_sqrt_cell, c2e_cordic_cell.
`include "assert_macros.svh"

module cubemap_to_equirect_address_core (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [2:0]                  face,
  input  logic [c2e_pkg::PW-1:0]      dst_x,
  input  logic [c2e_pkg::PW-1:0]      dst_y,
  input  logic                        cfg_we,
  input  logic [1:0]                  cfg_index,
  input  logic [c2e_pkg::CFGW-1:0]    cfg_data,
  output logic                        done,
  output logic [c2e_pkg::COLW-1:0]    src_col,
  output logic [c2e_pkg::ROWW-1:0]    src_row,
  output logic [c2e_pkg::OFFW-1:0]    src_byte_offset
);

  localparam int PW    = c2e_pkg::PW;
  localparam int NW    = c2e_pkg::NW;
  localparam int WW    = c2e_pkg::WW;
  localparam int HW    = c2e_pkg::HW;
  localparam int CHW   = c2e_pkg::CHW;
  localparam int QW    = c2e_pkg::QW;
  localparam int NUMW  = c2e_pkg::NUMW;
  localparam int UW    = c2e_pkg::UW;
  localparam int DW    = c2e_pkg::DW;
  localparam int RW    = c2e_pkg::RW;
  localparam int RADW  = c2e_pkg::RADW;
  localparam int CW    = c2e_pkg::CW;
  localparam int AW    = c2e_pkg::AW;
  localparam int COLW  = c2e_pkg::COLW;
  localparam int ROWW  = c2e_pkg::ROWW;
  localparam int OFFW  = c2e_pkg::OFFW;
  localparam int NSTEP = c2e_pkg::CORDIC_STEPS;
  localparam int SIDE_W = 1 + 3 * DW;
  localparam logic signed [UW-1:0] ONE_Q = UW'(1 << c2e_pkg::FRAC_BITS);

  // ---------------- configuration ----------------
  logic [NW-1:0]  face_size;
  logic [WW-1:0]  src_width;
  logic [HW-1:0]  src_height;
  logic [CHW-1:0] src_channels;

  always_ff @(posedge clk) begin
    if (rst) begin
      face_size    <= NW'(512);
      src_width    <= WW'(2048);
      src_height   <= HW'(1024);
      src_channels <= CHW'(3);
    end else if (cfg_we) begin
      case (cfg_index)
        c2e_pkg::REG_FACE_SIZE:    face_size    <= cfg_data[NW-1:0];
        c2e_pkg::REG_SRC_WIDTH:    src_width    <= cfg_data[WW-1:0];
        c2e_pkg::REG_SRC_HEIGHT:   src_height   <= cfg_data[HW-1:0];
        c2e_pkg::REG_SRC_CHANNELS: src_channels <= cfg_data[CHW-1:0];
        default: ;
      endcase
    end
  end

  logic [NW-1:0]  n_c;
  logic [WW-1:0]  w_c;
  logic [HW-1:0]  h_c;
  logic [CHW-1:0] ch_c;
  logic [NW-1:0]  n_m1;

  always_comb begin
    if (face_size == '0) n_c = NW'(1);
    else if (face_size > NW'(c2e_pkg::MAX_FACE_SIZE)) n_c = NW'(c2e_pkg::MAX_FACE_SIZE);
    else n_c = face_size;
    if (src_width == '0) w_c = WW'(1);
    else if (src_width > WW'(c2e_pkg::MAX_SRC_WIDTH)) w_c = WW'(c2e_pkg::MAX_SRC_WIDTH);
    else w_c = src_width;
    if (src_height == '0) h_c = HW'(1);
    else if (src_height > HW'(c2e_pkg::SRC_HEIGHT_CAP)) h_c = HW'(c2e_pkg::SRC_HEIGHT_CAP);
    else h_c = src_height;
    if (src_channels < CHW'(3)) ch_c = CHW'(3);
    else if (src_channels > CHW'(4)) ch_c = CHW'(4);
    else ch_c = src_channels;
    n_m1 = n_c - NW'(1);
  end

  // ---------------- input stage ----------------
  logic in_acc;
  assign in_acc = start && !busy;

  always_ff @(posedge clk) begin
    busy <= rst;
  end

  logic          s0_valid;
  logic [2:0]    s0_face;
  logic [PW-1:0] s0_px, s0_py;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else begin
      s0_valid <= in_acc;
    end
  end

  always_ff @(posedge clk) begin
    s0_face <= face;
    s0_px   <= ({1'b0, dst_x} > n_m1) ? n_m1[PW-1:0] : dst_x;
    s0_py   <= ({1'b0, dst_y} > n_m1) ? n_m1[PW-1:0] : dst_y;
  end

  logic [NUMW-1:0] num_u, num_v;
  assign num_u = {s0_px, 1'b1, {c2e_pkg::FRAC_BITS{1'b0}}};
  assign num_v = {s0_py, 1'b1, {c2e_pkg::FRAC_BITS{1'b0}}};

  // ---------------- divider chain ----------------
  logic          d_valid [0:QW];
  logic [2:0]    d_face  [0:QW];
  logic [NW-1:0] d_rem_u [0:QW];
  logic [QW-1:0] d_low_u [0:QW];
  logic [QW-1:0] d_quo_u [0:QW];
  logic [NW-1:0] d_rem_v [0:QW];
  logic [QW-1:0] d_low_v [0:QW];
  logic [QW-1:0] d_quo_v [0:QW];

  assign d_valid[0] = s0_valid;
  assign d_face[0]  = s0_face;
  assign d_rem_u[0] = NW'(num_u[NUMW-1:QW]);
  assign d_low_u[0] = num_u[QW-1:0];
  assign d_quo_u[0] = '0;
  assign d_rem_v[0] = NW'(num_v[NUMW-1:QW]);
  assign d_low_v[0] = num_v[QW-1:0];
  assign d_quo_v[0] = '0;

  for (genvar gi = 0; gi < QW; gi++) begin : g_div
    c2e_div_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .divisor   (n_c),
      .in_valid  (d_valid[gi]),
      .in_face   (d_face[gi]),
      .in_rem_u  (d_rem_u[gi]),
      .in_low_u  (d_low_u[gi]),
      .in_quo_u  (d_quo_u[gi]),
      .in_rem_v  (d_rem_v[gi]),
      .in_low_v  (d_low_v[gi]),
      .in_quo_v  (d_quo_v[gi]),
      .out_valid (d_valid[gi+1]),
      .out_face  (d_face[gi+1]),
      .out_rem_u (d_rem_u[gi+1]),
      .out_low_u (d_low_u[gi+1]),
      .out_quo_u (d_quo_u[gi+1]),
      .out_rem_v (d_rem_v[gi+1]),
      .out_low_v (d_low_v[gi+1]),
      .out_quo_v (d_quo_v[gi+1])
    );
  end

  // ---------------- face mapping ----------------
  logic signed [UW-1:0] u_q, v_q;
  logic signed [UW-1:0] mx, my, mz;

  always_comb begin
    u_q = $signed({1'b0, d_quo_u[QW]}) - ONE_Q;
    v_q = $signed({1'b0, d_quo_v[QW]}) - ONE_Q;
    case (d_face[QW])
      c2e_pkg::FACE_PX: begin mx = ONE_Q;  my = -v_q;   mz = -u_q;   end
      c2e_pkg::FACE_NX: begin mx = -ONE_Q; my = -v_q;   mz = u_q;    end
      c2e_pkg::FACE_PY: begin mx = u_q;    my = ONE_Q;  mz = v_q;    end
      c2e_pkg::FACE_NY: begin mx = u_q;    my = -ONE_Q; mz = -v_q;   end
      c2e_pkg::FACE_PZ: begin mx = u_q;    my = -v_q;   mz = ONE_Q;  end
      default:          begin mx = -u_q;   my = -v_q;   mz = -ONE_Q; end
    endcase
  end

  logic                 m_valid, m_bad;
  logic signed [DW-1:0] m_dx, m_dy, m_dz;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else begin
      m_valid <= d_valid[QW];
    end
  end

  always_ff @(posedge clk) begin
    m_bad <= d_face[QW] > c2e_pkg::FACE_NZ;
    m_dx  <= {mx, {c2e_pkg::GUARD_BITS{1'b0}}};
    m_dy  <= {my, {c2e_pkg::GUARD_BITS{1'b0}}};
    m_dz  <= {mz, {c2e_pkg::GUARD_BITS{1'b0}}};
  end

  // ---------------- squares and sum ----------------
  logic signed [2*DW-1:0] prod_x, prod_z;
  assign prod_x = m_dx * m_dx;
  assign prod_z = m_dz * m_dz;

  logic                 q_valid;
  logic [SIDE_W-1:0]    q_side;
  logic [RADW-3:0]      q_sqx, q_sqz;

  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else begin
      q_valid <= m_valid;
    end
  end

  always_ff @(posedge clk) begin
    q_side <= {m_bad, m_dx, m_dy, m_dz};
    q_sqx  <= prod_x[RADW-3:0];
    q_sqz  <= prod_z[RADW-3:0];
  end

  logic              a_valid;
  logic [SIDE_W-1:0] a_side;
  logic [RADW-1:0]   a_rad;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else begin
      a_valid <= q_valid;
    end
  end

  always_ff @(posedge clk) begin
    a_side <= q_side;
    a_rad  <= {2'b00, q_sqx} + {2'b00, q_sqz};
  end

  // ---------------- square root chain ----------------
  logic              r_valid [0:RW];
  logic [SIDE_W-1:0] r_side  [0:RW];
  logic [RW+1:0]     r_rem   [0:RW];
  logic [RADW-1:0]   r_rad   [0:RW];
  logic [RW-1:0]     r_root  [0:RW];

  assign r_valid[0] = a_valid;
  assign r_side[0]  = a_side;
  assign r_rem[0]   = '0;
  assign r_rad[0]   = a_rad;
  assign r_root[0]  = '0;

  for (genvar gr = 0; gr < RW; gr++) begin : g_sqrt
    c2e_sqrt_cell #(
      .SIDE_W (SIDE_W)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (r_valid[gr]),
      .in_side   (r_side[gr]),
      .in_rem    (r_rem[gr]),
      .in_rad    (r_rad[gr]),
      .in_root   (r_root[gr]),
      .out_valid (r_valid[gr+1]),
      .out_side  (r_side[gr+1]),
      .out_rem   (r_rem[gr+1]),
      .out_rad   (r_rad[gr+1]),
      .out_root  (r_root[gr+1])
    );
  end

  // ---------------- CORDIC setup ----------------
  logic                 sd_bad;
  logic signed [DW-1:0] sd_dx, sd_dy, sd_dz;
  assign {sd_bad, sd_dx, sd_dy, sd_dz} = r_side[RW];

  logic signed [CW-1:0] ext_dx, ext_dz;
  assign ext_dx = CW'(sd_dx);
  assign ext_dz = CW'(sd_dz);

  logic                 c_valid [0:NSTEP];
  logic                 c_bad   [0:NSTEP];
  logic signed [CW-1:0] c_lon_x [0:NSTEP];
  logic signed [CW-1:0] c_lon_y [0:NSTEP];
  logic [AW-1:0]        c_lon_a [0:NSTEP];
  logic signed [CW-1:0] c_lat_x [0:NSTEP];
  logic signed [CW-1:0] c_lat_y [0:NSTEP];
  logic [AW-1:0]        c_lat_a [0:NSTEP];

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid[0] <= 1'b0;
    end else begin
      c_valid[0] <= r_valid[RW];
    end
  end

  // a negative x on the longitude lane starts half a turn around
  always_ff @(posedge clk) begin
    c_bad[0] <= sd_bad;
    if (sd_dx[DW-1]) begin
      c_lon_x[0] <= -ext_dx;
      c_lon_y[0] <= -ext_dz;
      c_lon_a[0] <= c2e_pkg::HALF_TURN;
    end else begin
      c_lon_x[0] <= ext_dx;
      c_lon_y[0] <= ext_dz;
      c_lon_a[0] <= '0;
    end
    c_lat_x[0] <= $signed(CW'(r_root[RW]));
    c_lat_y[0] <= CW'(sd_dy);
    c_lat_a[0] <= '0;
  end

  for (genvar gc = 0; gc < NSTEP; gc++) begin : g_cordic
    c2e_cordic_cell #(
      .STEP (gc)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (c_valid[gc]),
      .in_bad    (c_bad[gc]),
      .in_lon_x  (c_lon_x[gc]),
      .in_lon_y  (c_lon_y[gc]),
      .in_lon_a  (c_lon_a[gc]),
      .in_lat_x  (c_lat_x[gc]),
      .in_lat_y  (c_lat_y[gc]),
      .in_lat_a  (c_lat_a[gc]),
      .out_valid (c_valid[gc+1]),
      .out_bad   (c_bad[gc+1]),
      .out_lon_x (c_lon_x[gc+1]),
      .out_lon_y (c_lon_y[gc+1]),
      .out_lon_a (c_lon_a[gc+1]),
      .out_lat_x (c_lat_x[gc+1]),
      .out_lat_y (c_lat_y[gc+1]),
      .out_lat_a (c_lat_a[gc+1])
    );
  end

  // ---------------- scale to source size ----------------
  logic [AW-1:0]    lon_f, lat_pos;
  logic [AW+WW-1:0] col_prod;
  logic [AW+HW-1:0] row_prod;

  always_comb begin
    lon_f    = c_lon_a[NSTEP] + c2e_pkg::HALF_TURN;
    lat_pos  = c2e_pkg::HALF_TURN - {c_lat_a[NSTEP][AW-2:0], 1'b0};
    col_prod = lon_f * w_c;
    row_prod = lat_pos * h_c;
  end

  logic            k_valid, k_bad;
  logic [COLW-1:0] k_col;
  logic [ROWW-1:0] k_row;

  always_ff @(posedge clk) begin
    if (rst) begin
      k_valid <= 1'b0;
    end else begin
      k_valid <= c_valid[NSTEP];
    end
  end

  always_ff @(posedge clk) begin
    k_bad <= c_bad[NSTEP];
    k_col <= col_prod[AW+COLW-1:AW];
    k_row <= row_prod[AW+ROWW-1:AW];
  end

  // ---------------- byte offset ----------------
  logic               o1_valid, o1_bad;
  logic [COLW-1:0]    o1_col;
  logic [ROWW-1:0]    o1_row;
  logic [ROWW+WW-1:0] o1_rw;

  always_ff @(posedge clk) begin
    if (rst) begin
      o1_valid <= 1'b0;
    end else begin
      o1_valid <= k_valid;
    end
  end

  always_ff @(posedge clk) begin
    o1_bad <= k_bad;
    o1_col <= k_col;
    o1_row <= k_row;
    o1_rw  <= k_row * w_c;
  end

  logic            o2_valid, o2_bad;
  logic [COLW-1:0] o2_col;
  logic [ROWW-1:0] o2_row;
  logic [OFFW-1:0] o2_idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      o2_valid <= 1'b0;
    end else begin
      o2_valid <= o1_valid;
    end
  end

  always_ff @(posedge clk) begin
    o2_bad <= o1_bad;
    o2_col <= o1_col;
    o2_row <= o1_row;
    o2_idx <= OFFW'(o1_rw) + OFFW'(o1_col);
  end

  logic [OFFW+CHW-1:0] off_prod;
  assign off_prod = o2_idx * ch_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= o2_valid;
    end
  end

  // drop the result of an unknown face to all zero
  always_ff @(posedge clk) begin
    src_col         <= o2_bad ? '0 : o2_col;
    src_row         <= o2_bad ? '0 : o2_row;
    src_byte_offset <= o2_bad ? '0 : off_prod[OFFW-1:0];
  end

  // ---------------- checks ----------------
  `ASSERT_NEXT(a_enter, clk, rst, in_acc, s0_valid)
  `ASSERT_IMPLIES(a_latency, clk, rst, done, $past(in_acc, c2e_pkg::LATENCY))
  `ASSERT_IMPLIES(a_col_range, clk, rst, done, {1'b0, src_col} < w_c)
  `ASSERT_IMPLIES(a_row_range, clk, rst, done, {1'b0, src_row} < h_c)

endmodule

// ===== sim/cubemap_to_equirect_address_core_tb.sv =====
// Testbench for cubemap_to_equirect_address_core: directed and random pixels
// checked against a bit-exact address predictor. Depends on c2e_pkg.
module cubemap_to_equirect_address_core_tb;

  typedef longint unsigned u64_t;

  typedef struct packed {
    logic [c2e_pkg::COLW-1:0] col;
    logic [c2e_pkg::ROWW-1:0] row;
    logic [c2e_pkg::OFFW-1:0] off;
  } src_addr_t;

  localparam int STALL_LIMIT = 1000;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     start = 1'b0;
  logic                     busy;
  logic [2:0]               face = '0;
  logic [c2e_pkg::PW-1:0]   dst_x = '0;
  logic [c2e_pkg::PW-1:0]   dst_y = '0;
  logic                     cfg_we = 1'b0;
  logic [1:0]               cfg_index = '0;
  logic [c2e_pkg::CFGW-1:0] cfg_data = '0;
  logic                     done;
  logic [c2e_pkg::COLW-1:0] src_col;
  logic [c2e_pkg::ROWW-1:0] src_row;
  logic [c2e_pkg::OFFW-1:0] src_byte_offset;

  logic            took = 1'b0;
  bit              quiet = 1'b0;
  int              errors = 0;
  int              stall = 0;
  u64_t            face_size_q, width_q, height_q, chan_q;
  src_addr_t       pending_addrs[$];

  cubemap_to_equirect_address_core dut (.*);

  always #2 clk = ~clk;

  // atan(2^-i) in 2^-32 turn
  bit [31:0] atan_step[0:27] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
    83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326,
    163, 81, 41, 20, 10, 5};

  function automatic u64_t clampv(u64_t v, u64_t lo, u64_t hi);
    return (v < lo) ? lo : (v > hi) ? hi : v;
  endfunction

  function automatic u64_t int_root(u64_t n);
    u64_t res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic bit [31:0] turn_angle(longint x, longint y);
    bit [31:0] ang;
    longint sx, sy;
    ang = 0;
    if (x < 0) begin
      x = -x;
      y = -y;
      ang = c2e_pkg::HALF_TURN;
    end
    for (int i = 0; i < c2e_pkg::CORDIC_STEPS && i < 28; i++) begin
      sx = y >>> i;
      sy = x >>> i;
      if (y >= 0) begin
        x += sx; y -= sy; ang += atan_step[i];
      end else begin
        x -= sx; y += sy; ang -= atan_step[i];
      end
    end
    return ang;
  endfunction

  function automatic longint centre(u64_t p, u64_t n);
    u64_t num;
    num = (2 * p + 1) << c2e_pkg::FRAC_BITS;
    return longint'(num / n) - (longint'(1) << c2e_pkg::FRAC_BITS);
  endfunction

  function automatic src_addr_t predict_addr(logic [2:0] f, logic [c2e_pkg::PW-1:0] x,
                                             logic [c2e_pkg::PW-1:0] y);
    u64_t n, w, h, ch, px, py, col, row, lon64, lat64, off;
    longint one, u, v, dx, dy, dz, r;
    bit [31:0] lon, lat;
    src_addr_t a;
    n = clampv(face_size_q, 1, c2e_pkg::MAX_FACE_SIZE);
    w = clampv(width_q, 1, c2e_pkg::MAX_SRC_WIDTH);
    h = clampv(height_q, 1, c2e_pkg::SRC_HEIGHT_CAP);
    ch = clampv(chan_q, 3, 4);
    px = clampv(u64_t'(x), 0, n - 1);
    py = clampv(u64_t'(y), 0, n - 1);
    one = longint'(1) << c2e_pkg::FRAC_BITS;
    a = '0;
    if (f > c2e_pkg::FACE_NZ) return a;
    u = centre(px, n);
    v = centre(py, n);
    case (f)
      c2e_pkg::FACE_PX: begin dx = one;  dy = -v;   dz = -u;   end
      c2e_pkg::FACE_NX: begin dx = -one; dy = -v;   dz = u;    end
      c2e_pkg::FACE_PY: begin dx = u;    dy = one;  dz = v;    end
      c2e_pkg::FACE_NY: begin dx = u;    dy = -one; dz = -v;   end
      c2e_pkg::FACE_PZ: begin dx = u;    dy = -v;   dz = one;  end
      default:          begin dx = -u;   dy = -v;   dz = -one; end
    endcase
    dx = dx << c2e_pkg::GUARD_BITS;
    dy = dy << c2e_pkg::GUARD_BITS;
    dz = dz << c2e_pkg::GUARD_BITS;
    r = longint'(int_root(u64_t'(dx * dx) + u64_t'(dz * dz)));
    lon = turn_angle(dx, dz) + c2e_pkg::HALF_TURN;
    lat = turn_angle(r, dy);
    lat = c2e_pkg::HALF_TURN - 2 * lat;
    lon64 = u64_t'(lon);
    lat64 = u64_t'(lat);
    col = (lon64 * w) >> 32;
    row = (lat64 * h) >> 32;
    off = (row * w + col) * ch;
    a.col = col[c2e_pkg::COLW-1:0];
    a.row = row[c2e_pkg::ROWW-1:0];
    a.off = off[c2e_pkg::OFFW-1:0];
    return a;
  endfunction

  // predict on every accepted beat, track register writes
  always @(posedge clk) begin
    took <= start && !busy && !rst;
    if (rst) begin
      face_size_q = 512; width_q = 2048; height_q = 1024; chan_q = 3;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          c2e_pkg::REG_FACE_SIZE:    face_size_q = u64_t'(cfg_data[12:0]);
          c2e_pkg::REG_SRC_WIDTH:    width_q = u64_t'(cfg_data[13:0]);
          c2e_pkg::REG_SRC_HEIGHT:   height_q = u64_t'(cfg_data[12:0]);
          c2e_pkg::REG_SRC_CHANNELS: chan_q = u64_t'(cfg_data[2:0]);
          default: ;
        endcase
      end
      if (start && !busy) pending_addrs.push_back(predict_addr(face, dst_x, dst_y));
    end
  end

  // compare each result beat with the oldest prediction
  always @(posedge clk) begin
    src_addr_t e;
    if (!rst && done) begin
      if (pending_addrs.size() == 0) begin
        $display("%0t: unexpected result col=%0d row=%0d off=%0d", $time,
                 src_col, src_row, src_byte_offset);
        errors++;
      end else begin
        e = pending_addrs.pop_front();
        if (src_col !== e.col) begin
          $display("%0t: src_col exp %0d got %0d", $time, e.col, src_col);
          errors++;
        end
        if (src_row !== e.row) begin
          $display("%0t: src_row exp %0d got %0d", $time, e.row, src_row);
          errors++;
        end
        if (src_byte_offset !== e.off) begin
          $display("%0t: src_byte_offset exp %0d got %0d", $time, e.off,
                   src_byte_offset);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done || cfg_we) begin
      stall <= 0;
    end else if (stall >= STALL_LIMIT) begin
      $display("cubemap_to_equirect_address_core_tb: done, errors");
      $finish;
    end else begin
      stall <= stall + 1;
    end
  end

  // call at a falling edge; start stays high so back-to-back beats need no toggle
  task automatic send_pixel(logic [2:0] f, logic [c2e_pkg::PW-1:0] x,
                            logic [c2e_pkg::PW-1:0] y);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk);
    end
    start <= 1'b1;
    face <= f;
    dst_x <= x;
    dst_y <= y;
    do @(negedge clk); while (!took);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (pending_addrs.size() != 0) @(negedge clk);
    repeat (c2e_pkg::LATENCY + 4) @(negedge clk);
  endtask

  task automatic write_regs(logic [c2e_pkg::CFGW-1:0] fs, logic [c2e_pkg::CFGW-1:0] w,
                            logic [c2e_pkg::CFGW-1:0] h, logic [c2e_pkg::CFGW-1:0] ch);
    logic [c2e_pkg::CFGW-1:0] vals[4];
    vals = '{fs, w, h, ch};
    drain();
    for (int i = 0; i < 4; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= i[1:0];
      cfg_data <= vals[i];
      @(negedge clk);
    end
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  function automatic logic [c2e_pkg::PW-1:0] pick_coord();
    u64_t n;
    n = clampv(face_size_q, 1, c2e_pkg::MAX_FACE_SIZE);
    if ($urandom_range(0, 7) == 0) return c2e_pkg::PW'($urandom);
    return c2e_pkg::PW'($urandom_range(0, int'(n - 1)));
  endfunction

  task automatic test_faces_and_corners();
    for (int f = 0; f < 8; f++) send_pixel(f[2:0], 0, 0);
    send_pixel(c2e_pkg::FACE_PX, 511, 511);
    send_pixel(c2e_pkg::FACE_NY, 0, 511);
    send_pixel(c2e_pkg::FACE_PZ, 255, 256);
    send_pixel(c2e_pkg::FACE_NZ, 4095, 4095);
  endtask

  task automatic test_register_extremes();
    write_regs(14'd4096, 14'd8192, 14'd4096, 14'd4);
    send_pixel(c2e_pkg::FACE_PX, 0, 4095);
    send_pixel(c2e_pkg::FACE_PY, 2047, 2048);
    send_pixel(c2e_pkg::FACE_NX, 4095, 0);
    write_regs(14'd0, 14'd0, 14'd0, 14'd0);
    send_pixel(c2e_pkg::FACE_PZ, 0, 0);
    send_pixel(c2e_pkg::FACE_NY, 7, 3);
    write_regs(14'h3FFF, 14'h3FFF, 14'h3FFF, 14'h7);
    send_pixel(c2e_pkg::FACE_NZ, 4095, 1);
    send_pixel(3'd6, 12, 12);
    write_regs(14'd1, 14'd1, 14'd1, 14'd3);
    send_pixel(c2e_pkg::FACE_PY, 0, 0);
    send_pixel(c2e_pkg::FACE_NX, 5, 9);
  endtask

  task automatic test_random_pixels();
    for (int p = 0; p < 9; p++) begin
      case (p % 3)
        0: write_regs(14'($urandom_range(1, 64)), 14'($urandom_range(1, 8192)),
                      14'($urandom_range(1, 4096)), 14'($urandom_range(3, 4)));
        1: write_regs(14'($urandom_range(1, 4096)), 14'($urandom),
                      14'($urandom), 14'($urandom_range(0, 7)));
        default: write_regs(14'd512, 14'd2048, 14'd1024, 14'd3);
      endcase
      quiet = (p == 8);
      for (int k = 0; k < 50; k++)
        send_pixel(($urandom_range(0, 15) == 0) ? 3'($urandom_range(6, 7))
                                                : 3'($urandom_range(0, 5)),
                   pick_coord(), pick_coord());
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_faces_and_corners();
    test_register_extremes();
    test_random_pixels();
    drain();
    if (errors == 0) begin
      $display("cubemap_to_equirect_address_core_tb: done, clean");
    end else begin
      $display("cubemap_to_equirect_address_core_tb: done, errors");
    end
    $finish;
  end

endmodule
